### sv/fcs_pkg.sv
// Package for the FIFO queue with content search.
// Holds the queue depth, operation and status codes, and the beat, token and command types.
// No dependencies.
package fcs_pkg;

  // Queue depth and the width of an entry counter that can hold it.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Operation codes carried in the opcode field.
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_MAX   = 2'd2,
    OP_COUNT = 2'd3
  } op_e;

  // Status codes reported with every result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Input beat.
  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
  } in_t;

  // Output beat.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] front_value;
    logic [4:0]         occupancy;
    logic               is_empty;
    logic signed [31:0] max_value;
    logic [4:0]         match_count;
  } out_t;

  // Search token that walks the cell chain one cell per cycle.
  typedef struct packed {
    logic               vld;
    logic               is_max;
    logic signed [31:0] key;
    logic signed [31:0] best;
    logic [CNT_W-1:0]   cnt;
  } tok_t;

  // Queue update command broadcast to every cell.
  typedef struct packed {
    logic               push;
    logic               pop;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

### sv/fcs_cell.sv
// One storage cell of the shifting queue, plus one stage of the search chain.
// Depends on fcs_pkg for the token and command types.
module fcs_cell import fcs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctl_t          ctl_i,
  input  logic               left_valid_i,
  input  logic               right_valid_i,
  input  logic signed [31:0] right_data_i,
  output logic               valid_o,
  output logic signed [31:0] data_o,
  input  tok_t               tok_i,
  output tok_t               tok_o
);

  logic               valid_q, valid_d;
  logic signed [31:0] data_q, data_d;
  tok_t               tok_q, tok_d;

  // A pop shifts every entry one cell toward the front; a push fills the
  // first empty cell, which is the one whose left neighbor is occupied.
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (ctl_i.pop) begin
      valid_d = right_valid_i;
      data_d  = right_data_i;
    end else if (ctl_i.push && !valid_q && left_valid_i) begin
      valid_d = 1'b1;
      data_d  = ctl_i.value;
    end
  end

  // Fold this cell's entry into the passing token.
  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && valid_q) begin
      if (tok_i.is_max) begin
        if (data_q > tok_i.best) begin
          tok_d.best = data_q;
        end
      end else if (data_q == tok_i.key) begin
        tok_d.cnt = tok_i.cnt + CNT_W'(1);
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  // Entry payload.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign tok_o   = tok_q;

endmodule

### sv/fifo_queue_with_content_search.sv
// Channel  | Signals                            | Beat
// input    | in_valid_i, in_ready_o, in_data_i  | in_t: opcode, value
// output   | out_valid_o, out_ready_i, out_data_o | out_t: status, front .. match_count
//
// Push and pop go through the update, then the result build.
// Query maximum and count first wait while a search token walks the
// chain of DEPTH cells, one cell per cycle, then build the result. Errors and pushes/pops skip the walk.
// Reset clears all cells to empty; entry payloads are not reset.
// A new item is taken while the previous result waits in the output register;
// the result build stalls only until that register frees.
//
// Top level of the FIFO queue with content search.
// Depends on fcs_pkg and fcs_cell.
module fifo_queue_with_content_search import fcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   occ_q, occ_d;
  logic [1:0]         status_q;
  logic signed [31:0] res_max_q;
  logic [CNT_W-1:0]   res_cnt_q;
  logic               out_valid_q;
  out_t               out_q;

  logic               accept, full, empty, is_scan_op;
  logic               do_push, do_pop, do_scan, load_out;
  logic [1:0]         status_new;
  cell_ctl_t          ctl;
  logic               cell_valid [DEPTH];
  logic signed [31:0] cell_data [DEPTH];
  tok_t               tok [DEPTH+1];

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (occ_q == CNT_W'(DEPTH));
  assign empty      = (occ_q == '0);
  assign is_scan_op = (in_data_i.opcode == OP_MAX) || (in_data_i.opcode == OP_COUNT);

  // Decide the command's outcome at acceptance.
  always_comb begin
    if (in_data_i.opcode == OP_PUSH) begin
      status_new = full ? ST_FULL : ST_OK;
    end else begin
      status_new = empty ? ST_EMPTY : ST_OK;
    end
  end

  assign do_push = accept && (in_data_i.opcode == OP_PUSH) && !full;
  assign do_pop  = accept && (in_data_i.opcode == OP_POP) && !empty;
  assign do_scan = accept && is_scan_op && !empty;

  assign ctl.push  = do_push;
  assign ctl.pop   = do_pop;
  assign ctl.value = in_data_i.value;

  // Token entering the first cell; the front entry seeds the maximum.
  assign tok[0].vld    = do_scan;
  assign tok[0].is_max = (in_data_i.opcode == OP_MAX);
  assign tok[0].key    = in_data_i.value;
  assign tok[0].best   = cell_data[0];
  assign tok[0].cnt    = '0;

  // Chain of cells, front at index zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic               left_valid, right_valid;
    logic signed [31:0] right_data;
    if (i == 0) begin : g_first
      assign left_valid = 1'b1;
    end else begin : g_mid
      assign left_valid = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_valid = 1'b0;
      assign right_data  = '0;
    end else begin : g_inner
      assign right_valid = cell_valid[i+1];
      assign right_data  = cell_data[i+1];
    end
    fcs_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .left_valid_i  (left_valid),
      .right_valid_i (right_valid),
      .right_data_i  (right_data),
      .valid_o       (cell_valid[i]),
      .data_o        (cell_data[i]),
      .tok_i         (tok[i]),
      .tok_o         (tok[i+1])
    );
  end

  // Occupancy tracking.
  always_comb begin
    occ_d = occ_q;
    if (do_push) begin
      occ_d = occ_q + CNT_W'(1);
    end else if (do_pop) begin
      occ_d = occ_q - CNT_W'(1);
    end
  end

  assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Sequencer: idle, for a search wait for the token to leave the chain, then build the result.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = do_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (tok[DEPTH].vld) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_new;
      res_max_q <= '0;
      res_cnt_q <= '0;
    end else if (state_q == S_SCAN && tok[DEPTH].vld) begin
      if (tok[DEPTH].is_max) begin
        res_max_q <= tok[DEPTH].best;
      end else begin
        res_cnt_q <= tok[DEPTH].cnt;
      end
    end
    if (load_out) begin
      out_q.status      <= status_q;
      out_q.front_value <= cell_valid[0] ? cell_data[0] : '0;
      out_q.occupancy   <= 5'(occ_q);
      out_q.is_empty    <= (occ_q == '0);
      out_q.max_value   <= res_max_q;
      out_q.match_count <= 5'(res_cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/fcs_checker.sv
// Port-level checker for the FIFO queue with content search, with its bind.
// Depends on fcs_pkg and binds to fifo_queue_with_content_search.
module fcs_checker import fcs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // Occupancy never exceeds the queue depth.
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.occupancy <= 5'(DEPTH))
    else $error("occupancy above depth");

  // The empty flag agrees with the occupancy.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_empty == (out_data_o.occupancy == 5'd0)))
    else $error("empty flag disagrees with occupancy");

  // An empty queue shows a zero front value.
  a_empty_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_empty |-> out_data_o.front_value == '0)
    else $error("front value not zero on empty queue");

  // An empty error leaves the queue empty and reports no search result.
  a_empty_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |->
      out_data_o.is_empty && out_data_o.max_value == '0 && out_data_o.match_count == 5'd0)
    else $error("empty error with nonempty result");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

endmodule

bind fifo_queue_with_content_search fcs_checker u_fcs_checker (.*);

### test/fifo_queue_with_content_search_tb.sv
// Self-checking testbench for the FIFO queue with content search.
// Drives directed and random command beats and checks every result beat.
// Depends on fcs_pkg and the fifo_queue_with_content_search top level.
`timescale 1ns / 100ps

module fifo_queue_with_content_search_tb;
  import fcs_pkg::*;

  localparam int unsigned RUN_LIMIT = 200_000;
  localparam int unsigned RANDOM_BEATS = 850;

  // Clock, reset and the two channels.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  // Hand-typed expectation that travels with the current command beat.
  logic beat_typed = 1'b0;
  out_t beat_want = '0;

  // Shadow copy of the queue contents.
  logic signed [31:0] q_slot[DEPTH];
  int unsigned q_head = 0;
  int unsigned q_tail = 0;
  int unsigned q_fill = 0;

  // Results still owed by the block, oldest first.
  out_t pending_results[$];
  out_t predicted;
  out_t oldest;

  // One directed command: repeated reps times, optionally with a typed result.
  typedef struct {
    in_t  beat;
    int   reps;
    bit   typed;
    out_t want;
  } dir_row_t;
  dir_row_t dir_rows[$];

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;

  fifo_queue_with_content_search dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Apply one command to the shadow queue and return the result it must give.
  function automatic out_t queue_apply(in_t cmd);
    out_t r;
    logic signed [31:0] best;
    int unsigned idx;
    int unsigned hits;
    r = '0;
    r.status = ST_OK;
    if (cmd.opcode == OP_PUSH) begin
      if (q_fill == DEPTH) begin
        r.status = ST_FULL;
      end else begin
        q_slot[q_tail] = cmd.value;
        q_tail = (q_tail + 1) % DEPTH;
        q_fill++;
      end
    end else if (q_fill == 0) begin
      r.status = ST_EMPTY;
    end else if (cmd.opcode == OP_POP) begin
      q_head = (q_head + 1) % DEPTH;
      q_fill--;
    end else if (cmd.opcode == OP_MAX) begin
      best = q_slot[q_head];
      for (int k = 0; k < q_fill; k++) begin
        idx = (q_head + k) % DEPTH;
        if (q_slot[idx] > best) best = q_slot[idx];
      end
      r.max_value = best;
    end else begin
      hits = 0;
      for (int k = 0; k < q_fill; k++) begin
        idx = (q_head + k) % DEPTH;
        if (q_slot[idx] == cmd.value) hits++;
      end
      r.match_count = 5'(hits);
    end
    r.front_value = (q_fill != 0) ? q_slot[q_head] : '0;
    r.occupancy = 5'(q_fill);
    r.is_empty = (q_fill == 0);
    return r;
  endfunction

  // Build a result beat by hand; the empty flag follows from the occupancy.
  function automatic out_t typed_result(status_e st, logic [31:0] front, int occ,
                                        logic [31:0] maxv, int hits);
    out_t r;
    r.status = st;
    r.front_value = front;
    r.occupancy = 5'(occ);
    r.is_empty = (occ == 0);
    r.max_value = maxv;
    r.match_count = 5'(hits);
    return r;
  endfunction

  task automatic dir_row(op_e op, logic [31:0] val, int reps, bit typed, out_t want);
    dir_row_t row;
    row.beat.opcode = op;
    row.beat.value = val;
    row.reps = reps;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // Offer one command beat, with bursts and gaps on the sending side.
  task automatic send_beat(in_t beat, bit typed, out_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    beat_typed <= typed;
    beat_want <= want;
    // Inputs only change at rising edges, so the falling edge shows the handshake.
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  // Random operand: a fixed phase value, wide values, extremes, or a narrow pool so that counts grow.
  function automatic logic [31:0] pick_value(int unsigned pool, logic [31:0] phase_val);
    case (pool)
      0: return phase_val;
      1: return 32'($signed($urandom_range(0, 4)) - 2);
      default: begin
        case ($urandom_range(0, 5))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          3: return 32'($signed($urandom_range(0, 4)) - 2);
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Receiver: ready pattern switches between always, mostly, sparse and coin flip.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 64);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= (stall_left[2:0] == 3'd0);
      default: out_ready_i <= 1'($urandom_range(0, 1));
    endcase
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("fifo_queue_with_content_search: mismatch");
      $finish;
    end
  end

  // Monitor: record accepted commands, then check accepted result beats.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predicted = queue_apply(in_data_i);
        pending_results.push_back(beat_typed ? beat_want : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no command outstanding");
          mismatches++;
        end else begin
          oldest = pending_results.pop_front();
          if (out_data_o.status !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, out_data_o.status);
            mismatches++;
          end
          if (out_data_o.front_value !== oldest.front_value) begin
            $error("front_value: expected %0d, got %0d",
                   oldest.front_value, out_data_o.front_value);
            mismatches++;
          end
          if (out_data_o.occupancy !== oldest.occupancy) begin
            $error("occupancy: expected %0d, got %0d",
                   oldest.occupancy, out_data_o.occupancy);
            mismatches++;
          end
          if (out_data_o.is_empty !== oldest.is_empty) begin
            $error("is_empty: expected %0d, got %0d", oldest.is_empty, out_data_o.is_empty);
            mismatches++;
          end
          if (out_data_o.max_value !== oldest.max_value) begin
            $error("max_value: expected %0d, got %0d",
                   oldest.max_value, out_data_o.max_value);
            mismatches++;
          end
          if (out_data_o.match_count !== oldest.match_count) begin
            $error("match_count: expected %0d, got %0d",
                   oldest.match_count, out_data_o.match_count);
            mismatches++;
          end
        end
      end
    end
  end

  // Stimulus: reset, directed table, random phases, then drain.
  initial begin
    in_t beat;
    int unsigned push_pct;
    int unsigned pool;
    logic [31:0] phase_val;

    // Empty-queue errors, extremes, fill to full, drop when full, wide counts.
    dir_row(OP_POP, 32'h0, 1, 1, typed_result(ST_EMPTY, 0, 0, 0, 0));
    dir_row(OP_MAX, 32'hFFFF_FFFF, 1, 1, typed_result(ST_EMPTY, 0, 0, 0, 0));
    dir_row(OP_COUNT, 32'h0, 1, 1, typed_result(ST_EMPTY, 0, 0, 0, 0));
    dir_row(OP_PUSH, 32'h8000_0000, 1, 1, typed_result(ST_OK, 32'h8000_0000, 1, 0, 0));
    dir_row(OP_PUSH, 32'h7FFF_FFFF, 1, 1, typed_result(ST_OK, 32'h8000_0000, 2, 0, 0));
    dir_row(OP_MAX, 32'h0, 1, 1,
            typed_result(ST_OK, 32'h8000_0000, 2, 32'h7FFF_FFFF, 0));
    dir_row(OP_COUNT, 32'h8000_0000, 1, 1, typed_result(ST_OK, 32'h8000_0000, 2, 0, 1));
    dir_row(OP_POP, 32'hFFFF_FFFF, 1, 1, typed_result(ST_OK, 32'h7FFF_FFFF, 1, 0, 0));
    dir_row(OP_PUSH, 32'hFFFF_FFFF, 15, 0, '0);
    dir_row(OP_PUSH, 32'h0, 1, 1, typed_result(ST_FULL, 32'h7FFF_FFFF, 16, 0, 0));
    dir_row(OP_COUNT, 32'hFFFF_FFFF, 1, 1, typed_result(ST_OK, 32'h7FFF_FFFF, 16, 0, 15));
    dir_row(OP_MAX, 32'h5555_AAAA, 1, 1,
            typed_result(ST_OK, 32'h7FFF_FFFF, 16, 32'h7FFF_FFFF, 0));
    dir_row(OP_POP, 32'h0, 1, 0, '0);
    dir_row(OP_COUNT, 32'h7FFF_FFFF, 1, 0, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      repeat (dir_rows[r].reps) send_beat(dir_rows[r].beat, dir_rows[r].typed,
                                          dir_rows[r].want);
    end

    // Random phases: each one leans toward filling, draining or a mix, and
    // draws operands from its own value pool.
    push_pct = 50;
    pool = 2;
    phase_val = 0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: push_pct = 85;
          1: push_pct = 20;
          2: push_pct = 65;
          default: push_pct = 45;
        endcase
        pool = $urandom_range(0, 2);
        phase_val = ($urandom_range(0, 1) != 0) ? $urandom : 32'h8000_0000;
      end
      beat.value = pick_value(pool, phase_val);
      if ($urandom_range(0, 99) < push_pct) begin
        beat.opcode = OP_PUSH;
      end else begin
        case ($urandom_range(0, 2))
          0: beat.opcode = OP_POP;
          1: beat.opcode = OP_MAX;
          default: begin
            beat.opcode = OP_COUNT;
            // Half the time search for a value that is held, so that hits are common.
            if (q_fill != 0 && $urandom_range(0, 1) != 0)
              beat.value = q_slot[(q_head + $urandom_range(0, q_fill - 1)) % DEPTH];
          end
        endcase
      end
      send_beat(beat, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // Wait for every owed result, then give the search walk time to go quiet.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("fifo_queue_with_content_search: match");
    end else begin
      $display("fifo_queue_with_content_search: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
sv/fcs_pkg.sv
sv/fcs_cell.sv
sv/fifo_queue_with_content_search.sv
sv/fcs_checker.sv
test/fifo_queue_with_content_search_tb.sv
